// File: sv/ffba_pkg.sv
// shared types and constants of the first fit block allocator
package ffba_pkg;

    localparam int STAT_W = 3;
    localparam int BYTE_W = 13;
    localparam int WORDS_W = 13;
    localparam int CFG_W = 11;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // operation codes
    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_SMALL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADFREE = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOINIT  = 3'd4;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]         op;
        logic [WORDS_W-1:0] words;
        logic [BYTE_W-1:0]  rel;
        logic [CFG_W-1:0]   pool_words;
    } cmd_t;

endpackage

// File: sv/ffba_ram.sv
// generic single port ram with registered read
module ffba_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: sv/ffba_front.sv
// request intake: config register, word rounding and push into the queue
module ffba_front
    import ffba_pkg::*;
#(
    parameter int WORD_BYTES = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam int SH = 17;
    localparam int RECIP = (2 ** SH + WORD_BYTES - 1) / WORD_BYTES;
    localparam int PROD_W = 32;

    logic [CFG_W-1:0]   pool_words_reg;
    logic [CFG_W-1:0]   pool_words_next;
    logic [BYTE_W-1:0]  req;
    logic [PROD_W-1:0]  rounded;
    logic [PROD_W-1:0]  prod;
    logic [WORDS_W-1:0] words;

    // config register
    always_comb begin
        pool_words_next = pool_words_reg;
        if (cfg_wr_en) begin
            pool_words_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_words_reg <= CFG_RESET;
        end else begin
            pool_words_reg <= pool_words_next;
        end
    end

    // round bytes up to words by reciprocal multiply, exact for 13 bit input
    assign req = s_tdata[14:2];
    assign rounded = PROD_W'(req) + PROD_W'(WORD_BYTES - 1);
    assign prod = rounded * PROD_W'(RECIP);
    assign words = (prod[SH +: WORDS_W] == '0) ? WORDS_W'(1) : prod[SH +: WORDS_W];

    // queue push
    assign s_tready = !q_full;
    assign q_push = s_tvalid && !q_full;
    assign q_cmd.op = s_tdata[1:0];
    assign q_cmd.words = words;
    assign q_cmd.rel = s_tdata[27:15];
    assign q_cmd.pool_words = pool_words_reg;

endmodule

// File: sv/ffba_queue.sv
// two entry request queue between front and back
module ffba_queue
    import ffba_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/ffba_back.sv
// header walker: executes init, allocate, free and query on the header store
module ffba_back
    import ffba_pkg::*;
#(
    parameter int POOL_WORDS = 1024,
    parameter int HEADER_WORDS = 1,
    parameter int WORD_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(POOL_WORDS);
    localparam int HW = AW + 2;
    localparam int CW = (AW + 6 > 16) ? AW + 6 : 16;
    localparam logic [CW-1:0] H_C = CW'(HEADER_WORDS);
    localparam logic [CW-1:0] WB_C = CW'(WORD_BYTES);
    localparam logic [CW-1:0] POOL_C = CW'(POOL_WORDS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT0  = 4'd1;
    localparam logic [3:0] S_INIT1  = 4'd2;
    localparam logic [3:0] S_RD     = 4'd3;
    localparam logic [3:0] S_EV     = 4'd4;
    localparam logic [3:0] S_RUNEND = 4'd5;
    localparam logic [3:0] S_SPLIT  = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic                ready_reg, ready_next;
    logic                oob_reg, oob_next;
    logic                in_run_reg, in_run_next;
    logic [1:0]          op_reg, op_next;
    logic [CW-1:0]       words_reg, words_next;
    logic [CW-1:0]       rel_reg, rel_next;
    logic [CW-1:0]       pwc_reg, pwc_next;
    logic [CW-1:0]       q_reg, q_next;
    logic [CW-1:0]       rs_reg, rs_next;
    logic [CW-1:0]       sum_reg, sum_next;
    logic [CW-1:0]       best_reg, best_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [BYTE_W-1:0]   poff_reg, poff_next;
    logic [BYTE_W-1:0]   largest_reg, largest_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [HW-1:0]       ram_wdata;
    logic [HW-1:0]       ram_rdata;

    logic signed [HW-1:0] h;
    logic [CW-1:0]       habs;
    logic [CW-1:0]       step;
    logic [CW-1:0]       off;
    logic [CW-1:0]       sz;
    logic [CW-1:0]       cfg_pw;
    logic [CW-1:0]       rs_off;
    logic [CW-1:0]       split_pos;

    ffba_ram #(
        .WIDTH (HW),
        .DEPTH (POOL_WORDS)
    ) u_hdr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // header decode and walk arithmetic
    assign h = oob_reg ? '0 : $signed(ram_rdata);
    assign habs = h[HW-1] ? CW'(-h) : CW'(h);
    assign step = q_reg + H_C + habs;
    assign off = (q_reg + H_C) * WB_C;
    assign sz = sum_reg - H_C;
    assign rs_off = (rs_reg + H_C) * WB_C;
    assign split_pos = rs_reg + H_C + words_reg;
    assign cfg_pw = (CW'(cmd.pool_words) > POOL_C) ? POOL_C : CW'(cmd.pool_words);

    // sequencer
    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        oob_next = oob_reg;
        in_run_next = in_run_reg;
        op_next = op_reg;
        words_next = words_reg;
        rel_next = rel_reg;
        pwc_next = pwc_reg;
        q_next = q_reg;
        rs_next = rs_reg;
        sum_next = sum_reg;
        best_next = best_reg;
        status_next = status_reg;
        poff_next = poff_reg;
        largest_next = largest_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        cmd_pop = 1'b0;
        ram_we = 1'b0;
        ram_addr = q_reg[AW-1:0];
        ram_wdata = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop = 1'b1;
                    op_next = cmd.op;
                    words_next = CW'(cmd.words);
                    rel_next = CW'(cmd.rel);
                    pwc_next = cfg_pw;
                    q_next = '0;
                    in_run_next = 1'b0;
                    best_next = '0;
                    status_next = ST_OK;
                    poff_next = '0;
                    largest_next = '0;
                    if (cmd.op == OP_INIT) begin
                        if (cfg_pw <= (H_C + H_C)) begin
                            status_next = ST_SMALL;
                            ready_next = 1'b0;
                            state_next = S_OUT;
                        end else begin
                            state_next = S_INIT0;
                        end
                    end else if (!ready_reg) begin
                        status_next = ST_NOINIT;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_INIT0: begin
                ram_we = 1'b1;
                ram_addr = '0;
                ram_wdata = HW'(pwc_reg - H_C - H_C);
                state_next = S_INIT1;
            end
            S_INIT1: begin
                ram_we = 1'b1;
                ram_addr = AW'(pwc_reg - H_C);
                ram_wdata = '0;
                ready_next = 1'b1;
                state_next = S_OUT;
            end
            S_RD: begin
                oob_next = (q_reg >= POOL_C);
                state_next = S_EV;
            end
            S_EV: begin
                if (op_reg == OP_FREE) begin
                    // free walks headers without merging
                    if (h == '0) begin
                        status_next = ST_BADFREE;
                        state_next = S_OUT;
                    end else if (off == rel_reg) begin
                        if (h[HW-1]) begin
                            ram_we = 1'b1;
                            ram_wdata = HW'(habs);
                        end else begin
                            status_next = ST_BADFREE;
                        end
                        state_next = S_OUT;
                    end else if (off > rel_reg) begin
                        status_next = ST_BADFREE;
                        state_next = S_OUT;
                    end else begin
                        q_next = step;
                        state_next = S_RD;
                    end
                end else if (h > 0) begin
                    // accumulate a free run
                    if (!in_run_reg) begin
                        rs_next = q_reg;
                        sum_next = habs + H_C;
                        in_run_next = 1'b1;
                    end else begin
                        sum_next = sum_reg + habs + H_C;
                    end
                    q_next = step;
                    state_next = S_RD;
                end else if (in_run_reg) begin
                    state_next = S_RUNEND;
                end else if (h == '0) begin
                    if (op_reg == OP_ALLOC) begin
                        status_next = ST_NOFIT;
                    end else begin
                        largest_next = BYTE_W'(best_reg * WB_C);
                    end
                    state_next = S_OUT;
                end else begin
                    q_next = step;
                    state_next = S_RD;
                end
            end
            S_RUNEND: begin
                // write back the merged run, or its taken header when an allocate fits
                ram_we = 1'b1;
                ram_addr = rs_reg[AW-1:0];
                ram_wdata = HW'(sz);
                in_run_next = 1'b0;
                state_next = S_RD;
                if (op_reg == OP_ALLOC) begin
                    if (sz >= words_reg + H_C + CW'(1)) begin
                        ram_wdata = HW'(CW'(0) - words_reg);
                        state_next = S_SPLIT;
                    end else if (sz >= words_reg) begin
                        ram_wdata = HW'(CW'(0) - sz);
                        poff_next = BYTE_W'(rs_off);
                        state_next = S_OUT;
                    end
                end else if (sz > best_reg) begin
                    best_next = sz;
                end
            end
            S_SPLIT: begin
                // remainder header after the taken words
                ram_we = (split_pos < POOL_C);
                ram_addr = split_pos[AW-1:0];
                ram_wdata = HW'(sz - words_reg - H_C);
                poff_next = BYTE_W'(rs_off);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next = {3'b000, largest_reg, poff_reg, status_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            in_run_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            m_valid_reg <= m_valid_next;
            in_run_reg <= in_run_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        oob_reg <= oob_next;
        op_reg <= op_next;
        words_reg <= words_next;
        rel_reg <= rel_next;
        pwc_reg <= pwc_next;
        q_reg <= q_next;
        rs_reg <= rs_next;
        sum_reg <= sum_next;
        best_reg <= best_next;
        status_reg <= status_next;
        poff_reg <= poff_next;
        largest_reg <= largest_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

endmodule

// File: sv/first_fit_block_allocator.sv
// top level of the first fit block allocator
//
// channel  direction  payload
// s_*      in         op, request_bytes, release_offset
// m_*      out        status, payload_offset, largest_bytes
// cfg_*    in         pool_words
//
// init writes the two boundary headers; allocate, free and query walk the
// headers one per read of the one port header ram.
// a two entry queue takes requests while the walker is busy.
// reset clears the sequencer, the ready and run flags, the queue, the output
// valid flag and the pool size register only.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int POOL_WORDS = 1024,
    parameter int HEADER_WORDS = 1,
    parameter int WORD_BYTES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op, request_bytes, release_offset
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // status, payload_offset, largest_bytes
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    ffba_front #(
        .WORD_BYTES (WORD_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    ffba_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    ffba_back #(
        .POOL_WORDS   (POOL_WORDS),
        .HEADER_WORDS (HEADER_WORDS),
        .WORD_BYTES   (WORD_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!q_empty),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
